// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module.
// Depends on nothing; each macro takes a label, a clock and a property, and CHK_CLKED also a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define CHK_CLKED(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("check failed: lbl");

// check a property on every clock edge, reset included
`define CHK_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("check failed: lbl");

`endif

// ----- rtl/hsc_pkg.sv -----
// Package for the hashed spawn cell decision block: item types, register
// indexes, hash and modulo constants, and a shared 32x32 multiply.
// Depends on nothing.
package hsc_pkg;

  localparam int unsigned BIOME_COUNT_DEF = 64;
  localparam int unsigned FLOOR_STEP      = 2;

  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MULT_A = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MULT_B = 64'h94D049BB133111EB;
  localparam int unsigned SH_A = 30;
  localparam int unsigned SH_B = 27;
  localparam int unsigned SH_C = 31;

  localparam logic [13:0] DENSITY_SCALE = 14'd10000;
  // 2^16, 2^32 and 2^48 reduced modulo the density scale
  localparam logic [12:0] RES_C1 = 13'd5536;
  localparam logic [12:0] RES_C2 = 13'd7296;
  localparam logic [12:0] RES_C3 = 13'd656;
  // floor(2^43 / 10000)
  localparam logic [29:0] RECIP       = 30'd879609302;
  localparam int unsigned RECIP_SHIFT = 43;

  typedef enum logic [2:0] {
    REG_CELL_SPACING = 3'd0,
    REG_DENSITY      = 3'd1,
    REG_MIN_HEIGHT   = 3'd2,
    REG_MAX_HEIGHT   = 3'd3,
    REG_VERT_OFFSET  = 3'd4,
    REG_RULE_SEED    = 3'd5,
    REG_WORLD_SEED   = 3'd6,
    REG_BIOME_MASK   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] column_x;
    logic signed [31:0] column_z;
    logic signed [31:0] surface_height;
    logic               biome_known;
    logic [5:0]         biome_id;
  } in_item_t;

  typedef struct packed {
    logic               placed;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [31:0]        instance_seed;
  } out_item_t;

  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

endpackage

// ----- rtl/hashed_spawn_cell_decision.sv -----
// Hashed spawn cell decision: one spawn rule tested against a stream of
// world column queries. Depends on hsc_pkg, hsc_floor and hsc_mix.
//
// Usage:
//   Configuration: write a register with cfg_wen, cfg_index (register number)
//   and cfg_wdata, only while no query is in flight; it takes effect for
//   queries accepted after the write.
//   Input: a query transfers when in_valid is high and in_stall is low.
//   Output: one result per query, in order; it transfers when out_valid is
//   high and out_stall is low. A result that is not placed reads all zero.
//   Pipeline: 40 register stages, made of the entry stage, the 17-stage
//   floor (16 remainder stages and the correction), two combine stages,
//   the three 5-stage hash mixers and 5 modulo stages.
//   Throughput: one query per cycle while the pipeline is not held by out_stall.
//   Stall: while a result waits under out_stall the whole pipeline holds and
//   in_stall is raised; nothing is lost or repeated.
//   Reset: rst is synchronous; it empties the pipeline and loads the register
//   defaults (spacing 8, threshold 0, full height window, offset 1).
module hashed_spawn_cell_decision #(
  parameter int unsigned BIOME_COUNT = hsc_pkg::BIOME_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  hsc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hsc_pkg::out_item_t  out_data
);

  typedef struct packed {
    logic               ok;
    logic signed [31:0] oy;
  } ent_side_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] oy;
    logic signed [31:0] ox;
    logic signed [32:0] oz;
  } p1_side_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] oy;
    logic signed [31:0] ox;
    logic signed [31:0] oz;
  } p2_side_t;

  typedef struct packed {
    logic               placed;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
  } fin_side_t;

  logic [15:0]        cell_spacing;
  logic [13:0]        density_threshold;
  logic signed [31:0] min_height;
  logic signed [31:0] max_height;
  logic signed [31:0] vertical_offset;
  logic [31:0]        rule_seed_offset;
  logic [31:0]        world_seed;
  logic [63:0]        biome_mask;

  logic [63:0] salt_lo;
  logic [31:0] salt_hi;
  logic [63:0] salt;

  logic adv;
  logic biome_ok, height_ok;

  logic               e_vld;
  logic signed [31:0] e_x, e_z;
  ent_side_t          e_side;

  logic               f_vld;
  logic signed [32:0] f_ox, f_oz;
  ent_side_t          f_side;

  logic        p1_vld;
  logic [63:0] p1_y;
  p1_side_t    p1_side;
  logic [63:0] p1_b;

  logic        x1_vld;
  logic [63:0] x1_hash;
  p1_side_t    x1_side;

  logic        p2_vld;
  logic [63:0] p2_y;
  p2_side_t    p2_side;
  logic [63:0] p2_b;

  logic        x2_vld;
  logic [63:0] x2_hash;
  p2_side_t    x2_side;

  logic        m1_vld, m2_vld, m3_vld, m4_vld, m5_vld;
  logic [63:0] m1_hash, m2_hash, m3_hash, m4_hash, m5_hash;
  p2_side_t    m1_side, m2_side, m3_side, m4_side;
  fin_side_t   m5_side;
  logic [15:0] m1_d0;
  logic [28:0] m1_p1, m1_p2;
  logic [25:0] m1_p3;
  logic [29:0] m2_v, m3_v;
  logic [59:0] m3_prod;
  logic [14:0] m4_r;
  logic [16:0] m4_q;
  logic [14:0] m5_r;
  logic        m5_pl;

  logic        x3_vld;
  logic [63:0] x3_hash;
  fin_side_t   x3_side;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_spacing      <= 16'd8;
      density_threshold <= 14'd0;
      min_height        <= 32'sh80000000;
      max_height        <= 32'sh7FFFFFFF;
      vertical_offset   <= 32'sd1;
      rule_seed_offset  <= 32'd0;
      world_seed        <= 32'd0;
      biome_mask        <= 64'd0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        hsc_pkg::REG_CELL_SPACING: cell_spacing      <= cfg_wdata[15:0];
        hsc_pkg::REG_DENSITY:      density_threshold <= cfg_wdata[13:0];
        hsc_pkg::REG_MIN_HEIGHT:   min_height        <= cfg_wdata[31:0];
        hsc_pkg::REG_MAX_HEIGHT:   max_height        <= cfg_wdata[31:0];
        hsc_pkg::REG_VERT_OFFSET:  vertical_offset   <= cfg_wdata[31:0];
        hsc_pkg::REG_RULE_SEED:    rule_seed_offset  <= cfg_wdata[31:0];
        hsc_pkg::REG_WORLD_SEED:   world_seed        <= cfg_wdata[31:0];
        hsc_pkg::REG_BIOME_MASK:   biome_mask        <= cfg_wdata;
      endcase
    end
  end

  // rule salt, rebuilt from the registers every cycle
  always_ff @(posedge clk) begin
    salt_lo <= hsc_pkg::mul32(rule_seed_offset, hsc_pkg::MULT_A[31:0]);
    salt_hi <= 32'(hsc_pkg::mul32(rule_seed_offset, hsc_pkg::MULT_A[63:32]));
    salt    <= {32'd0, world_seed} ^ (salt_lo + {salt_hi, 32'd0});
  end

  assign biome_ok = (biome_mask == 64'd0) ||
                    (in_data.biome_known &&
                     ({1'b0, in_data.biome_id} < 7'(BIOME_COUNT)) &&
                     biome_mask[in_data.biome_id]);
  assign height_ok = (in_data.surface_height >= min_height) &&
                     (in_data.surface_height <= max_height);

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= in_valid;
    end
    if (adv) begin
      e_x       <= in_data.column_x;
      e_z       <= in_data.column_z;
      e_side.ok <= biome_ok && height_ok && (cell_spacing != 16'd0);
      e_side.oy <= in_data.surface_height + vertical_offset;
    end
  end

  hsc_floor #(
    .SW ($bits(ent_side_t))
  ) u_floor (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (e_vld),
    .in_x     (e_x),
    .in_z     (e_z),
    .spacing  (cell_spacing),
    .in_side  (e_side),
    .out_vld  (f_vld),
    .out_ox   (f_ox),
    .out_oz   (f_oz),
    .out_side (f_side)
  );

  // combine salt with the cell x
  assign p1_b = {{31{f_ox[32]}}, f_ox};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (adv) begin
      p1_vld <= f_vld;
    end
    if (adv) begin
      p1_y       <= salt ^ (p1_b + hsc_pkg::GOLDEN + (salt << 6) + (salt >> 2));
      p1_side.ok <= f_side.ok;
      p1_side.oy <= f_side.oy;
      p1_side.ox <= f_ox[31:0];
      p1_side.oz <= f_oz;
    end
  end

  hsc_mix #(
    .SW ($bits(p1_side_t))
  ) u_mix_x (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (p1_vld),
    .in_y     (p1_y),
    .in_side  (p1_side),
    .out_vld  (x1_vld),
    .out_hash (x1_hash),
    .out_side (x1_side)
  );

  // combine with the cell z
  assign p2_b = {{31{x1_side.oz[32]}}, x1_side.oz};

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (adv) begin
      p2_vld <= x1_vld;
    end
    if (adv) begin
      p2_y       <= x1_hash ^ (p2_b + hsc_pkg::GOLDEN + (x1_hash << 6) + (x1_hash >> 2));
      p2_side.ok <= x1_side.ok;
      p2_side.oy <= x1_side.oy;
      p2_side.ox <= x1_side.ox;
      p2_side.oz <= x1_side.oz[31:0];
    end
  end

  hsc_mix #(
    .SW ($bits(p2_side_t))
  ) u_mix_z (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (p2_vld),
    .in_y     (p2_y),
    .in_side  (p2_side),
    .out_vld  (x2_vld),
    .out_hash (x2_hash),
    .out_side (x2_side)
  );

  // hash modulo the density scale: fold 16-bit digits, then reciprocal
  assign m4_q = m3_prod[hsc_pkg::RECIP_SHIFT +: 17];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
      m4_vld <= 1'b0;
      m5_vld <= 1'b0;
    end else if (adv) begin
      m1_vld <= x2_vld;
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
      m4_vld <= m3_vld;
      m5_vld <= m4_vld;
    end
    if (adv) begin
      m1_hash <= x2_hash;
      m1_side <= x2_side;
      m1_d0   <= x2_hash[15:0];
      m1_p1   <= 29'(x2_hash[31:16]) * 29'(hsc_pkg::RES_C1);
      m1_p2   <= 29'(x2_hash[47:32]) * 29'(hsc_pkg::RES_C2);
      m1_p3   <= 26'(x2_hash[63:48]) * 26'(hsc_pkg::RES_C3);

      m2_hash <= m1_hash;
      m2_side <= m1_side;
      m2_v    <= 30'(m1_d0) + 30'(m1_p1) + 30'(m1_p2) + 30'(m1_p3);

      m3_hash <= m2_hash;
      m3_side <= m2_side;
      m3_v    <= m2_v;
      m3_prod <= 60'(m2_v) * 60'(hsc_pkg::RECIP);

      m4_hash <= m3_hash;
      m4_side <= m3_side;
      m4_r    <= 15'(m3_v - 30'(m4_q) * 30'(hsc_pkg::DENSITY_SCALE));

      m5_hash        <= m4_hash;
      m5_side.placed <= m5_pl;
      m5_side.ox     <= m5_pl ? m4_side.ox : 32'sd0;
      m5_side.oy     <= m5_pl ? m4_side.oy : 32'sd0;
      m5_side.oz     <= m5_pl ? m4_side.oz : 32'sd0;
    end
  end

  assign m5_r  = (m4_r >= 15'(hsc_pkg::DENSITY_SCALE)) ?
                 15'(m4_r - 15'(hsc_pkg::DENSITY_SCALE)) : m4_r;
  assign m5_pl = m4_side.ok && (m5_r < 15'(density_threshold));

  hsc_mix #(
    .SW ($bits(fin_side_t))
  ) u_mix_seed (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (m5_vld),
    .in_y     (m5_hash),
    .in_side  (m5_side),
    .out_vld  (x3_vld),
    .out_hash (x3_hash),
    .out_side (x3_side)
  );

  assign out_valid = x3_vld;

  always_comb begin
    out_data.placed        = x3_side.placed;
    out_data.origin_x      = x3_side.ox;
    out_data.origin_y      = x3_side.oy;
    out_data.origin_z      = x3_side.oz;
    out_data.instance_seed = x3_side.placed ? x3_hash[31:0] : 32'd0;
  end

endmodule

// ----- rtl/hsc_floor.sv -----
// Pipelined floor of x and z to the cell spacing: two remainder bits per
// stage, then the floor correction. Depends on hsc_pkg.
module hsc_floor #(
  parameter int unsigned SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_z,
  input  logic [15:0]         spacing,
  input  logic [SW-1:0]       in_side,
  output logic                out_vld,
  output logic signed [32:0]  out_ox,
  output logic signed [32:0]  out_oz,
  output logic [SW-1:0]       out_side
);

  localparam int unsigned NST = 32 / hsc_pkg::FLOOR_STEP;

  logic               vld  [NST];
  logic [SW-1:0]      side [NST];
  logic signed [31:0] val  [NST][2];
  logic [31:0]        mag  [NST][2];
  logic [15:0]        rem  [NST][2];

  function automatic logic signed [32:0] fl_adj(input logic signed [31:0] v,
                                                input logic [15:0] r,
                                                input logic [15:0] s);
    logic [15:0] rf;
    rf = (v[31] && r != 16'd0) ? 16'(s - r) : r;
    return {v[31], v} - {17'd0, rf};
  endfunction

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic               cv;
    logic [SW-1:0]      cs;
    logic signed [31:0] cval [2];
    logic [31:0]        cmag [2];
    logic [15:0]        crem [2];
    logic [15:0]        nrem [2];

    if (k == 0) begin : g_first
      always_comb begin
        cv      = in_vld;
        cs      = in_side;
        cval[0] = in_x;
        cval[1] = in_z;
        for (int l = 0; l < 2; l++) begin
          cmag[l] = cval[l][31] ? (~cval[l] + 32'd1) : cval[l];
          crem[l] = '0;
        end
      end
    end else begin : g_rest
      always_comb begin
        cv = vld[k-1];
        cs = side[k-1];
        for (int l = 0; l < 2; l++) begin
          cval[l] = val[k-1][l];
          cmag[l] = mag[k-1][l];
          crem[l] = rem[k-1][l];
        end
      end
    end

    always_comb begin : p_step
      logic [16:0] t;
      logic [15:0] r;
      for (int l = 0; l < 2; l++) begin
        r = crem[l];
        for (int j = 0; j < hsc_pkg::FLOOR_STEP; j++) begin
          t = {r, cmag[l][31-j]};
          if (t >= {1'b0, spacing}) begin
            t = t - {1'b0, spacing};
          end
          r = t[15:0];
        end
        nrem[l] = r;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= cv;
      end
      if (adv) begin
        side[k] <= cs;
        for (int l = 0; l < 2; l++) begin
          val[k][l] <= cval[l];
          mag[k][l] <= cmag[l] << hsc_pkg::FLOOR_STEP;
          rem[k][l] <= nrem[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vld[NST-1];
    end
    if (adv) begin
      out_side <= side[NST-1];
      out_ox   <= fl_adj(val[NST-1][0], rem[NST-1][0], spacing);
      out_oz   <= fl_adj(val[NST-1][1], rem[NST-1][1], spacing);
    end
  end

endmodule

// ----- rtl/hsc_mix.sv -----
// Five-stage splitmix64 finaliser; each 64-bit multiply is split into
// 32x32 partial products and summed in the next stage. Depends on hsc_pkg.
module hsc_mix #(
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [63:0]   in_y,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [63:0]   out_hash,
  output logic [SW-1:0] out_side
);

  logic          vld  [4];
  logic [SW-1:0] side [4];
  logic [63:0]   s1, s3;
  logic [63:0]   a0, b0;
  logic [31:0]   a1, a2, b1, b2;
  logic [63:0]   t, u, w;

  assign t = in_y + hsc_pkg::GOLDEN;
  assign u = a0 + {a1 + a2, 32'd0};
  assign w = b0 + {b1 + b2, 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) vld[i] <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld[0]  <= in_vld;
      vld[1]  <= vld[0];
      vld[2]  <= vld[1];
      vld[3]  <= vld[2];
      out_vld <= vld[3];
    end
    if (adv) begin
      side[0]  <= in_side;
      side[1]  <= side[0];
      side[2]  <= side[1];
      side[3]  <= side[2];
      out_side <= side[3];
      s1 <= t ^ (t >> hsc_pkg::SH_A);
      a0 <= hsc_pkg::mul32(s1[31:0], hsc_pkg::MULT_A[31:0]);
      a1 <= 32'(hsc_pkg::mul32(s1[63:32], hsc_pkg::MULT_A[31:0]));
      a2 <= 32'(hsc_pkg::mul32(s1[31:0], hsc_pkg::MULT_A[63:32]));
      s3 <= u ^ (u >> hsc_pkg::SH_B);
      b0 <= hsc_pkg::mul32(s3[31:0], hsc_pkg::MULT_B[31:0]);
      b1 <= 32'(hsc_pkg::mul32(s3[63:32], hsc_pkg::MULT_B[31:0]));
      b2 <= 32'(hsc_pkg::mul32(s3[31:0], hsc_pkg::MULT_B[63:32]));
      out_hash <= w ^ (w >> hsc_pkg::SH_C);
    end
  end

endmodule

// ----- rtl/hsc_checker.sv -----
// Port-level checks for the hashed spawn cell decision block, bound to the
// top level. Depends on hsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hsc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input hsc_pkg::out_item_t out_data
);

  `CHK_CLKED(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data))
  `CHK_CLKED(a_backpressure, clk, rst, out_valid && out_stall |-> in_stall)
  `CHK_CLKED(a_unplaced_zero, clk, rst, out_valid && !out_data.placed |-> out_data[127:0] == '0)
  `CHK_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind hashed_spawn_cell_decision hsc_checker u_hsc_checker (.*);
